FILE: rtl/core/sglle_pkg.sv
package sglle_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W    = 2;
  localparam int PIX_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_BOTH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VLOG = 2'd1;

  localparam logic [CFG_W-1:0] RST_WIDTH  = 13'd1024;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 13'd1024;

  localparam int NBANK   = 32;
  localparam int BANK_W  = 5;
  localparam int NTAP    = 24;
  localparam int GTAP    = 12;
  localparam int HALF    = NTAP / 2;
  localparam int GHALF   = GTAP / 2;
  localparam int LAG     = GTAP - 1;
  localparam int PRELOAD = NTAP - 1;
  localparam int GROUP   = 6;

  localparam int TOK_MAX = 4;
  localparam int TOK_W   = 3;

  localparam int VL_W  = 18;
  localparam int SUM_W = 28;
  localparam int T_W   = 22;
  localparam int REC_W = 14;
  localparam int REM_W = 15;

  localparam int OFFSET       = 128;
  localparam int DIV_BOTH     = 16288;
  localparam int DIV_BOX      = 384;
  localparam int RECIP_SHIFT  = 22;
  localparam int RECIP_BOTH   = (1 << RECIP_SHIFT) / DIV_BOTH;
  localparam int RECIP_BOX    = (1 << RECIP_SHIFT) / DIV_BOX;

  typedef struct packed {
    logic valid;
    logic has_out;
    logic last;
  } push_flags_t;

  typedef struct packed {
    logic valid;
    logic last;
  } out_flags_t;

  function automatic int gauss_tap(int i);
    case (i)
      0: return 10;   1: return 18;   2: return 29;   3: return 43;
      4: return 57;   5: return 67;   6: return 71;   7: return 67;
      8: return 57;   9: return 43;  10: return 29;  11: return 18;
      default: return 0;
    endcase
  endfunction

  function automatic int log_tap(int i);
    case (i)
      0: return -1;    1: return -2;    2: return -4;    3: return -9;
      4: return -15;   5: return -20;   6: return -22;   7: return -16;
      8: return 0;     9: return 22;   10: return 42;   11: return 50;
      12: return 42;  13: return 22;   14: return 0;    15: return -16;
      16: return -22; 17: return -20;  18: return -15;  19: return -9;
      20: return -4;  21: return -2;   22: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int cell_hg(int k);
    if (k >= GHALF && k <= PRELOAD - GHALF) return gauss_tap(PRELOAD - GHALF - k);
    return 0;
  endfunction

  function automatic int cell_hl(int k);
    return log_tap(PRELOAD - k);
  endfunction

endpackage

FILE: rtl/core/sglle_bank.sv
module sglle_bank #(
  parameter int DEPTH = sglle_pkg::DEF_MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AW-1:0]              waddr_i,
  input  logic [sglle_pkg::PIX_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AW-1:0]              raddr_i,
  output logic [sglle_pkg::PIX_W-1:0] rdata_o
);
  import sglle_pkg::*;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sglle_cell.sv
module sglle_cell #(
  parameter int HG = 0,
  parameter int HL = 0
) (
  input  logic                              clk_i,
  input  logic                              shift_i,
  input  logic signed [sglle_pkg::VL_W-1:0]  vlog_i,
  input  logic signed [sglle_pkg::VL_W-1:0]  vg_i,
  input  logic signed [sglle_pkg::SUM_W-1:0] part_i,
  output logic signed [sglle_pkg::SUM_W-1:0] part_o
);
  import sglle_pkg::*;

  logic signed [SUM_W-1:0] part_d, part_q;

  assign part_d = part_i + SUM_W'(HG * int'(vlog_i)) + SUM_W'(HL * int'(vg_i));

  always_ff @(posedge clk_i) begin
    if (shift_i) part_q <= part_d;
  end

  assign part_o = part_q;

endmodule

FILE: rtl/core/sglle_scale.sv
module sglle_scale (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              box_i,
  input  sglle_pkg::out_flags_t              flags_i,
  input  logic signed [sglle_pkg::SUM_W-1:0] sum_i,
  output logic                              valid_o,
  output logic [sglle_pkg::PIX_W-1:0]        pixel_o,
  output logic                              last_o
);
  import sglle_pkg::*;

  out_flags_t f1_q, f2_q, f3_q, f4_q;
  logic [T_W-1:0]   t1_d, t1_q, t2_q;
  logic [PIX_W-1:0] q0_d, q0_q;
  logic [REM_W-1:0] rem3_d, rem3_q;
  logic [PIX_W-1:0] q3_q, pix_d, pix_q;
  logic [T_W+REC_W-1:0] prod;
  logic [T_W-1:0]   qd;
  logic signed [SUM_W-1:0] tsum;
  int div, recip;

  assign div   = box_i ? DIV_BOX : DIV_BOTH;
  assign recip = box_i ? RECIP_BOX : RECIP_BOTH;

  always_comb begin
    tsum = sum_i + SUM_W'(OFFSET * div);
    if (tsum < 0) t1_d = '0;
    else if (int'(tsum) > 2 * OFFSET * div - 1) t1_d = T_W'(2 * OFFSET * div - 1);
    else t1_d = T_W'(tsum);
  end

  assign prod  = (T_W+REC_W)'(t1_q) * (T_W+REC_W)'(recip);
  assign q0_d  = prod[RECIP_SHIFT+PIX_W-1:RECIP_SHIFT];
  assign qd    = T_W'(int'(q0_q) * div);
  assign rem3_d = REM_W'(t2_q - qd);

  always_comb begin
    logic [PIX_W:0]   q;
    logic [REM_W:0]   r;
    logic             up;
    q = {1'b0, q3_q};
    r = {1'b0, rem3_q};
    if (int'(rem3_q) >= div) begin
      q = q + 1'b1;
      r = r - (REM_W+1)'(div);
    end
    up = (int'(r) * 2 > div) || ((int'(r) * 2 == div) && q[0]);
    q = q + (PIX_W+1)'(up);
    pix_d = q[PIX_W] ? '1 : q[PIX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_q <= '0;
      f2_q <= '0;
      f3_q <= '0;
      f4_q <= '0;
    end else if (en_i) begin
      f1_q <= flags_i;
      f2_q <= f1_q;
      f3_q <= f2_q;
      f4_q <= f3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t1_d;
      t2_q   <= t1_q;
      q0_q   <= q0_d;
      q3_q   <= q0_q;
      rem3_q <= rem3_d;
      pix_q  <= pix_d;
    end
  end

  assign valid_o = f4_q.valid;
  assign last_o  = f4_q.last;
  assign pixel_o = pix_q;

endmodule

FILE: rtl/core/separable_gauss_log_line_enhance_core.sv
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------
// input    | in_valid_i/in_stall_o | pixel_in_i, flush_i
// output   | out_valid_o/out_stall_i | pixel_out_o, frame_last_o
// config   | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One input transaction per cycle while in_stall_o is low; each output row is pushed through the
// cell chain after PRELOAD pushes prime it, and input stalls once 4 results wait for that chain.
// A result read from the line banks then passes the group-sum, vertical-sum, cell-chain and scale registers.
// No clearing pass after reset; pushed columns use only line bank entries already written.
// A new frame's first pixel waits until the last column of the previous frame is read.
module separable_gauss_log_line_enhance_core #(
  parameter int MAX_WIDTH  = sglle_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = sglle_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sglle_pkg::PIX_W-1:0]      pixel_in_i,
  input  logic                            flush_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sglle_pkg::PIX_W-1:0]      pixel_out_o,
  output logic                            frame_last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sglle_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sglle_pkg::CFG_W-1:0]      cfg_data_i
);
  import sglle_pkg::*;

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int UW = $clog2(MAX_WIDTH + NTAP);
  localparam int LW = HW + 5;
  localparam int CW = WW + 5;

  logic [CFG_W-1:0]  width_q, height_q;
  logic [MODE_W-1:0] mode_q;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic cfg_wr, size_wr, box_mode, vlog_only;

  logic [WW-1:0] ic_q, ic_d, oc_q, oc_d;
  logic [HW-1:0] ir_q, ir_d, or_q, or_d;
  logic          done_q, done_d, fe_q, fe_d, be_q, be_d;
  logic [BANK_W-1:0] wbank_q, wbank_d, base_q, base_d;
  logic [TOK_W-1:0]  tok_q, tok_d;
  logic acc, pix_wr, issue, elig;
  logic [LW-1:0] lr;
  logic [CW-1:0] lc;

  logic [HW-1:0] brow_q, brow_d;
  logic [UW-1:0] bu_q, bu_d;
  logic en, push, consume, row_end, has_out;
  logic [AW-1:0] raddr;
  logic [BANK_W-1:0] sel_d [NTAP];
  logic [BANK_W-1:0] sel_q [NTAP];
  push_flags_t rd_flags_q, v1_flags_q, v2_flags_q;
  out_flags_t  c_flags_q;

  logic [PIX_W-1:0] bank_rd [NBANK];
  logic signed [PIX_W-1:0] taps [NTAP];
  logic signed [VL_W-1:0] lg_d [NTAP/GROUP];
  logic signed [VL_W-1:0] lg_q [NTAP/GROUP];
  logic signed [VL_W-1:0] gg_d [GTAP/GROUP];
  logic signed [VL_W-1:0] gg_q [GTAP/GROUP];
  logic signed [VL_W-1:0] vlog_d, vlog_q, vg_d, vg_q;
  logic signed [SUM_W-1:0] part [NTAP+1];
  logic scale_valid;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr  = cfg_valid_i;
  assign size_wr = cfg_wr && (cfg_index_i == REG_WIDTH || cfg_index_i == REG_HEIGHT);
  assign box_mode  = mode_q[1];
  assign vlog_only = (mode_q == MODE_VLOG);

  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if ({1'b0, width_q} > (CFG_W+1)'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = HW'(1);
    else if ({1'b0, height_q} > (CFG_W+1)'(MAX_HEIGHT)) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      mode_q   <= MODE_BOTH;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        REG_WIDTH:  width_q  <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        REG_MODE:   mode_q   <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (tok_q >= TOK_W'(TOK_MAX)) || (fe_q != be_q);
  assign acc    = in_valid_i && !in_stall_o;
  assign pix_wr = acc && !flush_i && !done_q;

  always_comb begin
    ic_d = ic_q;
    ir_d = ir_q;
    done_d = done_q;
    wbank_d = wbank_q;
    oc_d = oc_q;
    or_d = or_q;
    fe_d = fe_q;
    if (pix_wr) begin
      if (ic_q == w_eff - 1'b1) begin
        ic_d = '0;
        ir_d = ir_q + 1'b1;
        wbank_d = wbank_q + 1'b1;
        if (ir_q == h_eff - 1'b1) done_d = 1'b1;
      end else begin
        ic_d = ic_q + 1'b1;
      end
    end
    lr = LW'(or_q) + LW'(LAG);
    if (lr > LW'(h_eff) - 1'b1) lr = LW'(h_eff) - 1'b1;
    lc = CW'(oc_q) + CW'(LAG);
    if (lc > CW'(w_eff) - 1'b1) lc = CW'(w_eff) - 1'b1;
    elig = done_d || (lr < LW'(ir_d)) || ((lr == LW'(ir_d)) && (lc < CW'(ic_d)));
    issue = acc && elig;
    if (issue) begin
      if (or_q == h_eff - 1'b1 && oc_q == w_eff - 1'b1) begin
        ic_d = '0;
        ir_d = '0;
        oc_d = '0;
        or_d = '0;
        done_d = 1'b0;
        fe_d = !fe_q;
      end else if (oc_q == w_eff - 1'b1) begin
        oc_d = '0;
        or_d = or_q + 1'b1;
      end else begin
        oc_d = oc_q + 1'b1;
      end
    end
  end

  assign tok_d = tok_q + TOK_W'(issue) - TOK_W'(consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q <= '0;
      ir_q <= '0;
      oc_q <= '0;
      or_q <= '0;
      done_q <= 1'b0;
      fe_q <= 1'b0;
      wbank_q <= '0;
      tok_q <= '0;
    end else if (size_wr) begin
      ic_q <= '0;
      ir_q <= '0;
      oc_q <= '0;
      or_q <= '0;
      done_q <= 1'b0;
      fe_q <= 1'b0;
      wbank_q <= '0;
      tok_q <= '0;
    end else begin
      ic_q <= ic_d;
      ir_q <= ir_d;
      oc_q <= oc_d;
      or_q <= or_d;
      done_q <= done_d;
      fe_q <= fe_d;
      wbank_q <= wbank_d;
      tok_q <= tok_d;
    end
  end

  assign en      = !(scale_valid && out_stall_i);
  assign push    = en && (tok_q != '0);
  assign has_out = bu_q >= UW'(PRELOAD);
  assign consume = push && has_out;
  assign row_end = (UW+1)'(bu_q) == (UW+1)'(w_eff) + (UW+1)'(PRELOAD - 1);

  always_comb begin
    brow_d = brow_q;
    bu_d = bu_q;
    base_d = base_q;
    be_d = be_q;
    if (push) begin
      if (row_end) begin
        bu_d = '0;
        if (brow_q == h_eff - 1'b1) begin
          brow_d = '0;
          base_d = base_q + BANK_W'(h_eff);
          be_d = !be_q;
        end else begin
          brow_d = brow_q + 1'b1;
        end
      end else begin
        bu_d = bu_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brow_q <= '0;
      bu_q <= '0;
      base_q <= '0;
      be_q <= 1'b0;
    end else if (size_wr) begin
      brow_q <= '0;
      bu_q <= '0;
      base_q <= '0;
      be_q <= 1'b0;
    end else begin
      brow_q <= brow_d;
      bu_q <= bu_d;
      base_q <= base_d;
      be_q <= be_d;
    end
  end

  always_comb begin
    int ri;
    int xc;
    for (int i = 0; i < NTAP; i++) begin
      ri = int'(brow_q) + i - HALF;
      if (ri < 0) ri = 0;
      if (ri > int'(h_eff) - 1) ri = int'(h_eff) - 1;
      sel_d[i] = BANK_W'(int'(base_q) + ri);
    end
    xc = int'(bu_q) - HALF;
    if (xc < 0) xc = 0;
    if (xc > int'(w_eff) - 1) xc = int'(w_eff) - 1;
    raddr = AW'(xc);
  end

  for (genvar k = 0; k < NBANK; k++) begin : g_bank
    sglle_bank #(.DEPTH(MAX_WIDTH)) u_bank (
      .clk_i   (clk_i),
      .we_i    (pix_wr && (wbank_q == BANK_W'(k))),
      .waddr_i (ic_q[AW-1:0]),
      .wdata_i (pixel_in_i),
      .re_i    (en),
      .raddr_i (raddr),
      .rdata_o (bank_rd[k])
    );
  end

  always_comb begin
    logic [PIX_W-1:0] b;
    int acc_v;
    for (int i = 0; i < NTAP; i++) begin
      b = bank_rd[sel_q[i]];
      taps[i] = {~b[PIX_W-1], b[PIX_W-2:0]};
    end
    for (int g = 0; g < NTAP / GROUP; g++) begin
      acc_v = 0;
      for (int j = 0; j < GROUP; j++) begin
        acc_v = acc_v + log_tap(g * GROUP + j) * int'(taps[g * GROUP + j]);
      end
      lg_d[g] = VL_W'(acc_v);
    end
    for (int g = 0; g < GTAP / GROUP; g++) begin
      acc_v = 0;
      for (int j = 0; j < GROUP; j++) begin
        if (box_mode) acc_v = acc_v + int'(taps[GHALF + g * GROUP + j]);
        else acc_v = acc_v + gauss_tap(g * GROUP + j) * int'(taps[GHALF + g * GROUP + j]);
      end
      gg_d[g] = VL_W'(acc_v);
    end
  end

  always_comb begin
    vlog_d = '0;
    vg_d = '0;
    if (!box_mode) begin
      for (int g = 0; g < NTAP / GROUP; g++) vlog_d = vlog_d + lg_q[g];
    end
    if (!vlog_only) begin
      for (int g = 0; g < GTAP / GROUP; g++) vg_d = vg_d + gg_q[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_flags_q <= '0;
      v1_flags_q <= '0;
      v2_flags_q <= '0;
      c_flags_q  <= '0;
    end else if (en) begin
      rd_flags_q <= '{valid: push, has_out: has_out, last: row_end && (brow_q == h_eff - 1'b1)};
      v1_flags_q <= rd_flags_q;
      v2_flags_q <= v1_flags_q;
      c_flags_q  <= '{valid: v2_flags_q.valid && v2_flags_q.has_out, last: v2_flags_q.last};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sel_q  <= sel_d;
      lg_q   <= lg_d;
      gg_q   <= gg_d;
      vlog_q <= vlog_d;
      vg_q   <= vg_d;
    end
  end

  assign part[NTAP] = '0;

  for (genvar k = 0; k < NTAP; k++) begin : g_cell
    sglle_cell #(.HG(cell_hg(k)), .HL(cell_hl(k))) u_cell (
      .clk_i   (clk_i),
      .shift_i (en && v2_flags_q.valid),
      .vlog_i  (vlog_q),
      .vg_i    (vg_q),
      .part_i  (part[k+1]),
      .part_o  (part[k])
    );
  end

  sglle_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .box_i   (box_mode),
    .flags_i (c_flags_q),
    .sum_i   (part[0]),
    .valid_o (scale_valid),
    .pixel_o (pixel_out_o),
    .last_o  (frame_last_o)
  );

  assign out_valid_o = scale_valid;

endmodule

FILE: rtl/core/sglle_checker.sv
module sglle_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [sglle_pkg::PIX_W-1:0] pixel_out_o,
  input logic                       frame_last_o
);
  import sglle_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_out_o) && $stable(frame_last_o))
    else $error("stalled output payload changed");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("block not idle in reset");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("input stall raised without an accepted transaction");

endmodule

bind separable_gauss_log_line_enhance_core sglle_checker u_sglle_checker (.*);
